// ===== src/cfq_pkg.sv =====
// Shared types and codes for the circular FIFO queue.
// No dependencies; imported by cfq_store, cfq_ctrl and circular_fifo_queue.
package cfq_pkg;

   typedef logic [1:0] func_type;
   typedef logic [1:0] error_type;

   localparam func_type FUNC_QUERY = 2'd0;
   localparam func_type FUNC_PUSH  = 2'd1;
   localparam func_type FUNC_POP   = 2'd2;

   localparam error_type ERR_OK    = 2'd0;
   localparam error_type ERR_EMPTY = 2'd1;
   localparam error_type ERR_FULL  = 2'd2;

   localparam int WORD_W = 32;

   // Status handed from the controller to the output register.
   typedef struct packed {
      logic      load;
      logic      is_empty;
      logic      is_full;
      error_type error_code;
   } status_type;

endpackage

// ===== src/cfq_store.sv =====
// Entry memory of the circular FIFO queue: one write port, two registered read ports.
// Depends on cfq_pkg for the word width.
module cfq_store #(
   parameter int DEPTH = 16,
   parameter int PTR_W = 4
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [PTR_W-1:0]          wr_addr,
   input  logic [cfq_pkg::WORD_W-1:0] wr_data,
   input  logic [PTR_W-1:0]          rd_head_addr,
   input  logic [PTR_W-1:0]          rd_last_addr,
   output logic [cfq_pkg::WORD_W-1:0] rd_head_data,
   output logic [cfq_pkg::WORD_W-1:0] rd_last_data
);
   import cfq_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_head_ff;
   logic [WORD_W-1:0] rd_last_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_head_ff <= mem[rd_head_addr];
      rd_last_ff <= mem[rd_last_addr];
   end

   assign rd_head_data = rd_head_ff;
   assign rd_last_data = rd_last_ff;

endmodule

// ===== src/cfq_ctrl.sv =====
// Pointer, count and sequencing logic of the circular FIFO queue.
// Depends on cfq_pkg; drives the write and read ports of cfq_store.
module cfq_ctrl #(
   parameter int DEPTH = 16,
   parameter int PTR_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  cfq_pkg::func_type    func,
   input  logic                 out_free,
   output logic                 ready,
   output logic                 wr_en,
   output logic [PTR_W-1:0]     wr_addr,
   output logic [PTR_W-1:0]     rd_head_addr,
   output logic [PTR_W-1:0]     rd_last_addr,
   output logic [CNT_W-1:0]     count,
   output cfq_pkg::status_type  status
);
   import cfq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_DONE = 3'b100
   } state_type;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   error_type        err_ff, err_in;
   logic             push_ok, pop_ok;

   assign push_ok = (func == FUNC_PUSH) && (count_ff != CNT_FULL);
   assign pop_ok  = (func == FUNC_POP) && (count_ff != '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      err_in   = err_ff;
      if (accept) begin
         err_in = ERR_OK;
         if (push_ok) begin
            tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end else if (pop_ok) begin
            head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end else if (func == FUNC_PUSH) begin
            err_in = ERR_FULL;
         end else if (func == FUNC_POP) begin
            err_in = ERR_EMPTY;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         err_ff   <= ERR_OK;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   assign ready        = (state_ff == S_IDLE);
   assign wr_en        = accept && push_ok;
   assign wr_addr      = tail_ff;
   // Reads run every cycle; pointers only move at an accepted transfer, so the
   // data seen in S_DONE stays valid for as long as the output is stalled.
   assign rd_head_addr = head_ff;
   assign rd_last_addr = (tail_ff == '0) ? PTR_LAST : tail_ff - 1'b1;
   assign count        = count_ff;

   assign status.load       = (state_ff == S_DONE) && out_free;
   assign status.is_empty   = (count_ff == '0);
   assign status.is_full    = (count_ff == CNT_FULL);
   assign status.error_code = err_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count exceeds depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with unequal pointers");

   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_FULL) |-> (head_ff == tail_ff))
      else $error("full queue with unequal pointers");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (accept && push_ok) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("accepted push did not advance the count");

   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_READ) && !ready)
      else $error("accepted transfer did not start a read");

endmodule

// ===== src/circular_fifo_queue.sv =====
// Circular FIFO queue of unsigned 32-bit words with a fixed depth.
//
// Input channel (req_): one transfer carries an operation in req_tuser
// (query, push or pop) and the word to push in req_tdata. Result channel
// (rsp_): one transfer per input transfer reports, after the operation, the
// oldest and newest stored words (zero when empty), the entry count, the
// empty and full flags and an error code (pop on empty, push on full).
// A rejected operation leaves the queue unchanged.
//
// Each item runs through the controller states in order: in S_IDLE the
// accept updates the pointers and writes the entry memory, in S_READ the
// head and tail entries are read from the memory, and in S_DONE the
// registered read data is loaded into the output register once it is free.
// The next item is accepted only back in S_IDLE, so the queue takes no new
// item before the last one is loaded into the output register.
// Reset empties the queue; memory contents are not cleared and need not be.
// When the receiver stalls, the result waits in the output register while
// one more item is taken and processed; that item then holds until the
// output register frees up.
module circular_fifo_queue #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,  // push_value[31:0]
   input  logic [1:0]           req_tuser,  // func[1:0]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // oldest_value[31:0], newest_value[63:32], entry_count, is_empty, is_full,
   // error_code, then zero fill to whole bytes
   output logic [((68 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import cfq_pkg::*;

   localparam int PTR_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int OUT_BITS = 2 * WORD_W + CNT_W + 4;
   localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

   logic              accept;
   logic              out_free;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [PTR_W-1:0]  rd_head_addr;
   logic [PTR_W-1:0]  rd_last_addr;
   logic [WORD_W-1:0] rd_head_data;
   logic [WORD_W-1:0] rd_last_data;
   logic [CNT_W-1:0]  count;
   status_type        status;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [WORD_W-1:0] oldest, newest;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   cfq_ctrl #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .func         (req_tuser),
      .out_free     (out_free),
      .ready        (req_tready),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .rd_head_addr (rd_head_addr),
      .rd_last_addr (rd_last_addr),
      .count        (count),
      .status       (status)
   );

   cfq_store #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_store (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (req_tdata),
      .rd_head_addr (rd_head_addr),
      .rd_last_addr (rd_last_addr),
      .rd_head_data (rd_head_data),
      .rd_last_data (rd_last_data)
   );

   assign oldest = status.is_empty ? '0 : rd_head_data;
   assign newest = status.is_empty ? '0 : rd_last_data;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (status.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = OUT_W'({status.error_code, status.is_full, status.is_empty,
                                count, newest, oldest});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !status.load)
      else $error("result loaded over a stalled transfer");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (status.load && status.is_empty) |=> (rsp_tdata[2*WORD_W-1:0] == '0))
      else $error("empty result carries nonzero words");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      status.load |-> !req_tready)
      else $error("new transfer accepted before the result was loaded");

endmodule
